@@ src/key_debounce_longpress_fsm_top_macros.svh @@
// assertion macros used by kdl_outq
`ifndef KEY_DEBOUNCE_LONGPRESS_FSM_TOP_MACROS_SVH
`define KEY_DEBOUNCE_LONGPRESS_FSM_TOP_MACROS_SVH

// same-cycle implication, quiet during reset
`define KDL_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define KDL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/kdl_pkg.sv @@
`timescale 1ns / 1ps

package kdl_pkg;

   // register indexes on the csr port
   localparam logic [2:0] CSR_DEBOUNCE  = 3'd0;
   localparam logic [2:0] CSR_REPEAT    = 3'd1;
   localparam logic [2:0] CSR_LONGPRESS = 3'd2;
   localparam logic [2:0] CSR_ACTLOW    = 3'd3;
   localparam logic [2:0] CSR_LOCK      = 3'd4;
   localparam logic [2:0] CSR_KEYCODE   = 3'd5;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // register reset values
   localparam logic [11:0] DEBOUNCE_RST  = 12'd20;
   localparam logic [11:0] REPEAT_RST    = 12'd100;
   localparam logic [15:0] LONGPRESS_RST = 16'd1000;

   // event values
   localparam logic [1:0] KEY_RELEASED = 2'd0;
   localparam logic [1:0] KEY_PRESSED  = 2'd1;
   localparam logic [1:0] KEY_LONG     = 2'd2;

   // result queue depth
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_DEBOUNCE = 2'd1,
      PH_PRESSED  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [11:0] debounce_ms;
      logic [11:0] repeat_ms;
      logic [15:0] longpress_ms;
      logic        level_invert;
      logic        key_lock;
      logic [9:0]  key_code;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [16:0] held_time;
      logic [11:0] countdown;
      logic        timer_armed;
      logic        prev_level;
   } state_type;

   // events raised by one tick, first in val0
   typedef struct packed {
      logic [1:0] num;
      logic [1:0] val0;
      logic [1:0] val1;
   } events_type;

endpackage

@@ src/key_debounce_longpress_fsm_top.sv @@
`timescale 1ns / 1ps
// channel   direction  handshake              word
// req       in         req_valid / req_stall  raw_level
// rsp       out        rsp_valid / rsp_stall  code, key_value, last
// csr       in         csr_valid / csr_ready  csr_index, csr_wdata
//
// a tick word is latched in the input register, then evaluated combinationally
// and its events written to the result queue once the queue has room; the first
// result is valid once it sits in the queue and is taken while rsp_stall is low.
// one word per cycle while each tick yields at most one event and rsp is not stalled;
// a tick with two events is read out as two rsp words, paced by the queue read port.
// reset clears key state and queue and loads register defaults; no clear pass.
// req_stall rises when the queue lacks room for two events behind a held tick.

module key_debounce_longpress_fsm_top #(
   parameter int QueueDepth = kdl_pkg::QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_raw_level,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [9:0]                     rsp_code,
   output logic [1:0]                     rsp_key_value,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [kdl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kdl_pkg::CSR_DATA_W-1:0] csr_wdata
);

   kdl_pkg::cfg_type    cfg;
   kdl_pkg::events_type events;
   logic                in_vld_ff, in_vld_in;
   logic                in_lvl_ff;
   logic                advance;
   logic                room;
   logic                req_take;

   assign csr_ready = 1'b1;

   // input register handshake
   assign advance   = in_vld_ff && room;
   assign req_stall = in_vld_ff && !room;
   assign req_take  = req_valid && !req_stall;
   assign in_vld_in = req_take || (in_vld_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_lvl_ff <= req_raw_level;
      end
   end

   kdl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kdl_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .level   (in_lvl_ff),
      .cfg     (cfg),
      .events  (events)
   );

   kdl_outq #(
      .Depth (QueueDepth)
   ) u_outq (
      .clock         (clock),
      .reset         (reset),
      .push          (advance),
      .events        (events),
      .code          (cfg.key_code),
      .room          (room),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_code      (rsp_code),
      .rsp_key_value (rsp_key_value),
      .rsp_last      (rsp_last)
   );

endmodule

@@ src/kdl_csr.sv @@
`timescale 1ns / 1ps

module kdl_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   input  logic [kdl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kdl_pkg::CSR_DATA_W-1:0] csr_wdata,
   output kdl_pkg::cfg_type               cfg
);

   kdl_pkg::cfg_type cfg_ff;
   kdl_pkg::cfg_type cfg_in;

   // register decode, unknown indexes dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            kdl_pkg::CSR_DEBOUNCE:  cfg_in.debounce_ms  = csr_wdata[11:0];
            kdl_pkg::CSR_REPEAT:    cfg_in.repeat_ms    = csr_wdata[11:0];
            kdl_pkg::CSR_LONGPRESS: cfg_in.longpress_ms = csr_wdata[15:0];
            kdl_pkg::CSR_ACTLOW:    cfg_in.level_invert = csr_wdata[0];
            kdl_pkg::CSR_LOCK:      cfg_in.key_lock     = csr_wdata[0];
            kdl_pkg::CSR_KEYCODE:   cfg_in.key_code     = csr_wdata[9:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms  <= kdl_pkg::DEBOUNCE_RST;
         cfg_ff.repeat_ms    <= kdl_pkg::REPEAT_RST;
         cfg_ff.longpress_ms <= kdl_pkg::LONGPRESS_RST;
         cfg_ff.level_invert <= 1'b0;
         cfg_ff.key_lock     <= 1'b0;
         cfg_ff.key_code     <= 10'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/kdl_core.sv @@
`timescale 1ns / 1ps

module kdl_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  level,
   input  kdl_pkg::cfg_type      cfg,
   output kdl_pkg::events_type   events
);

   typedef struct packed {
      kdl_pkg::state_type  st;
      kdl_pkg::events_type ev;
   } work_type;

   kdl_pkg::state_type state_ff;
   kdl_pkg::state_type state_in;
   work_type           work;

   function automatic work_type emit(work_type w, logic [1:0] v);
      work_type r;
      r = w;
      if (w.ev.num == 2'd0) begin
         r.ev.val0 = v;
         r.ev.num  = 2'd1;
      end else if (w.ev.num == 2'd1) begin
         r.ev.val1 = v;
         r.ev.num  = 2'd2;
      end
      return r;
   endfunction

   function automatic work_type arm(work_type w, logic [11:0] t);
      work_type r;
      r = w;
      r.st.countdown   = (t == 12'd0) ? 12'd1 : t;
      r.st.timer_armed = 1'b1;
      return r;
   endfunction

   // key evaluation against the current phase
   function automatic work_type evaluate(work_type w, logic lvl, kdl_pkg::cfg_type c);
      work_type r;
      logic     pressed;
      r = w;
      pressed = lvl ^ c.level_invert;
      if (w.st.phase == kdl_pkg::PH_DEBOUNCE) begin
         if (pressed) begin
            r = emit(r, kdl_pkg::KEY_PRESSED);
            r.st.held_time = 17'd0;
            r.st.phase     = kdl_pkg::PH_PRESSED;
            r = arm(r, c.repeat_ms);
         end else begin
            r.st.phase       = kdl_pkg::PH_IDLE;
            r.st.timer_armed = 1'b0;
         end
      end else if (w.st.phase == kdl_pkg::PH_PRESSED) begin
         if (pressed) begin
            if (w.st.held_time >= {1'b0, c.longpress_ms}) begin
               r = emit(r, kdl_pkg::KEY_LONG);
               r.st.held_time = 17'd0;
            end else begin
               r.st.held_time = w.st.held_time + {5'd0, c.repeat_ms};
            end
            r = arm(r, c.repeat_ms);
         end else begin
            r = emit(r, kdl_pkg::KEY_RELEASED);
            r.st.held_time   = 17'd0;
            r.st.phase       = kdl_pkg::PH_IDLE;
            r.st.timer_armed = 1'b0;
         end
      end
      return r;
   endfunction

   // one tick: timer first, then the pin edge
   always_comb begin
      work        = '0;
      work.st     = state_ff;
      if (state_ff.timer_armed) begin
         work.st.countdown = (state_ff.countdown == 12'd0) ? 12'd0
                           : state_ff.countdown - 12'd1;
         if (work.st.countdown == 12'd0) begin
            work.st.timer_armed = 1'b0;
            work = evaluate(work, level, cfg);
         end
      end
      if ((level != state_ff.prev_level) && !cfg.key_lock) begin
         if (cfg.debounce_ms != 12'd0) begin
            if (level) begin
               work.st.phase = kdl_pkg::PH_DEBOUNCE;
               work = arm(work, cfg.debounce_ms);
            end
         end else begin
            work = evaluate(work, level, cfg);
         end
      end
      work.st.prev_level = level;
   end

   assign state_in = advance ? work.st : state_ff;

   // key state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase       <= kdl_pkg::PH_IDLE;
         state_ff.held_time   <= 17'd0;
         state_ff.countdown   <= 12'd0;
         state_ff.timer_armed <= 1'b0;
         state_ff.prev_level  <= 1'b0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign events = work.ev;

endmodule

@@ src/kdl_outq.sv @@
`timescale 1ns / 1ps
`include "key_debounce_longpress_fsm_top_macros.svh"

module kdl_outq #(
   parameter int Depth = kdl_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  kdl_pkg::events_type events,
   input  logic [9:0]          code,
   output logic                room,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [9:0]          rsp_code,
   output logic [1:0]          rsp_key_value,
   output logic                rsp_last
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [CntW-1:0] DepthC = CntW'(Depth);
   localparam logic [CntW-1:0] RoomC  = CntW'(Depth - 2);

   typedef struct packed {
      logic [9:0] code;
      logic [1:0] value;
      logic       last;
   } entry_type;

   entry_type         mem_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic [PtrW-1:0]   wr_ptr_nx;
   logic [CntW-1:0]   push_n;
   logic              pop;

   function automatic logic [PtrW-1:0] inc(logic [PtrW-1:0] p);
      return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
   endfunction

   // two free words always available before a push
   assign room      = (cnt_ff <= RoomC);
   assign rsp_valid = (cnt_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign push_n    = push ? CntW'(events.num) : '0;
   assign wr_ptr_nx = inc(wr_ptr_ff);

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push_n == CntW'(1)) begin
         wr_ptr_in = wr_ptr_nx;
      end else if (push_n == CntW'(2)) begin
         wr_ptr_in = inc(wr_ptr_nx);
      end
      rd_ptr_in = pop ? inc(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff + push_n - (pop ? CntW'(1) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // event storage, second word marked last when present, else the first
   always_ff @(posedge clock) begin
      if (push_n != '0) begin
         mem_ff[wr_ptr_ff].code  <= code;
         mem_ff[wr_ptr_ff].value <= events.val0;
         mem_ff[wr_ptr_ff].last  <= (events.num == 2'd1);
      end
      if (push_n == CntW'(2)) begin
         mem_ff[wr_ptr_nx].code  <= code;
         mem_ff[wr_ptr_nx].value <= events.val1;
         mem_ff[wr_ptr_nx].last  <= 1'b1;
      end
   end

   assign rsp_code      = mem_ff[rd_ptr_ff].code;
   assign rsp_key_value = mem_ff[rd_ptr_ff].value;
   assign rsp_last      = mem_ff[rd_ptr_ff].last;

   // queue checks
   `KDL_ASSERT_IMPL(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= DepthC, "queue overfilled")
   `KDL_ASSERT_IMPL(a_push_room, clock, reset, push_n != '0, room, "push without room")
   `KDL_ASSERT_NEXT(a_cnt_track, clock, reset, 1'b1,
                    cnt_ff == $past(cnt_ff) + $past(push_n) - CntW'($past(pop)),
                    "fill count mismatch")
   `KDL_ASSERT_IMPL(a_two_last, clock, reset, push && events.num == 2'd2,
                    events.val0 != kdl_pkg::KEY_RELEASED || events.val1 == kdl_pkg::KEY_RELEASED,
                    "release followed by other event")

endmodule
